// ----- rtl/ddcm_pkg.sv -----
package ddcm_pkg;

    // Deck geometry
    localparam int MAX_CARDS = 256;
    localparam int DEPTH     = 2 * MAX_CARDS;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int FILL_W    = $clog2(DEPTH + 1);

    // Field widths
    localparam int FUNC_W = 2;
    localparam int CODE_W = 4;
    localparam int SIZE_W = 9;
    localparam int CARD_W = 10;
    localparam int CNT_W  = 10;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP  = 2'd3;

    // Move code bit positions
    localparam int MC_SRC_RIGHT  = 3;
    localparam int MC_SRC_BOTTOM = 2;
    localparam int MC_DST_RIGHT  = 1;
    localparam int MC_DST_BOTTOM = 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_FIN
    } state_t;

    // base + off modulo DEPTH; base < DEPTH, off <= DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [FILL_W-1:0] off);
        logic [FILL_W:0] s;
        s = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
        if (s >= (FILL_W + 1)'(DEPTH))
            s = s - (FILL_W + 1)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] h);
        return (h == IDX_W'(DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] h);
        return (h == '0) ? IDX_W'(DEPTH - 1) : h - 1'b1;
    endfunction

endpackage

// ----- rtl/ddcm_if.sv -----
interface ddcm_cmd_if;
    import ddcm_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] move_code;
    logic              read_deck;

    modport source (output valid, func, move_code, read_deck, input ready);
    modport sink   (input valid, func, move_code, read_deck, output ready);
endinterface

interface ddcm_rsp_if;
    import ddcm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CARD_W-1:0] card_value;
    logic                     card_valid;
    logic [CNT_W-1:0]         left_count;
    logic [CNT_W-1:0]         right_count;

    modport source (output valid, card_value, card_valid, left_count, right_count,
                    input ready);
    modport sink   (input valid, card_value, card_valid, left_count, right_count,
                    output ready);
endinterface

interface ddcm_cfg_if;
    import ddcm_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/ddcm_ram.sv -----
module ddcm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dual_deque_card_mover.sv -----
// Channel  Dir  Handshake          Payload
// cfg      in   cfg.valid/ready    data (deck size N, 9 bits)
// cmd      in   cmd.valid/ready    func, move_code, read_deck
// rsp      out  rsp.valid/ready    card_value, card_valid, left_count, right_count
//
// Move, readout and no-op items: the accept cycle issues the
// deck RAM read; the finish state pushes a moved card and loads the result.
// Init does one RAM write per card into both decks, in parallel.
// Reset (rst_n low) empties both decks and clears deck size; no RAM sweep.
// A new item is taken while the previous result still waits in the output
// register; the finishing cycle holds until that register is free.
module dual_deque_card_mover (
    input  logic      clk,
    input  logic      rst_n,
    ddcm_cfg_if.sink  cfg,
    ddcm_cmd_if.sink  cmd,
    ddcm_rsp_if.source rsp
);

    import ddcm_pkg::*;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [SIZE_W-1:0] deck_size_reg;

    logic [IDX_W-1:0]  left_head_reg,  left_head_next;
    logic [FILL_W-1:0] left_fill_reg,  left_fill_next;
    logic [IDX_W-1:0]  right_head_reg, right_head_next;
    logic [FILL_W-1:0] right_fill_reg, right_fill_next;
    logic [FILL_W-1:0] init_n_reg,     init_n_next;

    // Item context held between accept and finish
    logic move_reg,       move_next;
    logic got_reg,        got_next;        // a card was popped
    logic src_right_reg,  src_right_next;
    logic dst_right_reg,  dst_right_next;
    logic dst_bottom_reg, dst_bottom_next;

    // Result register
    logic                     out_valid_reg;
    logic signed [CARD_W-1:0] out_card_reg,   out_card_next;
    logic                     out_cvalid_reg, out_cvalid_next;
    logic [CNT_W-1:0]         out_lcnt_reg,   out_lcnt_next;
    logic [CNT_W-1:0]         out_rcnt_reg,   out_rcnt_next;

    // ---------------------------------------------------------------
    // Deck RAMs
    // ---------------------------------------------------------------
    logic              l_we, l_re, r_we, r_re;
    logic [IDX_W-1:0]  l_waddr, r_waddr, rd_addr;
    logic [CARD_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

    ddcm_ram #(.WIDTH(CARD_W), .DEPTH(DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (rd_addr),
        .rdata (l_rdata)
    );

    ddcm_ram #(.WIDTH(CARD_W), .DEPTH(DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (rd_addr),
        .rdata (r_rdata)
    );

    // ---------------------------------------------------------------
    // Decode of the incoming item
    // ---------------------------------------------------------------
    logic              acc;
    logic              is_init, is_move, is_read;
    logic              src_r, src_bot, take;
    logic [IDX_W-1:0]  s_head, pop_addr;
    logic [FILL_W-1:0] s_fill, s_fill_m1, init_n;
    logic              out_free;
    logic              init_busy;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign acc       = cmd.valid && cmd.ready;
    assign is_init   = (cmd.func == FUNC_INIT);
    assign is_move   = (cmd.func == FUNC_MOVE);
    assign is_read   = (cmd.func == FUNC_READ);
    assign src_r     = is_move ? cmd.move_code[MC_SRC_RIGHT] : cmd.read_deck;
    assign src_bot   = is_move && cmd.move_code[MC_SRC_BOTTOM];
    assign s_head    = src_r ? right_head_reg : left_head_reg;
    assign s_fill    = src_r ? right_fill_reg : left_fill_reg;
    assign s_fill_m1 = s_fill - 1'b1;
    assign take      = acc && (is_move || is_read) && (s_fill != '0);
    // bottom card sits at head + fill - 1
    assign pop_addr  = src_bot ? ring_add(s_head, s_fill_m1) : s_head;
    assign init_busy = (left_fill_reg != init_n_reg);

    always_comb
    begin
        if (32'(deck_size_reg) > 32'(MAX_CARDS))
            init_n = FILL_W'(MAX_CARDS);
        else
            init_n = FILL_W'(deck_size_reg);
    end

    // Push target on the destination deck (after the pop took effect)
    logic [IDX_W-1:0]  d_head, push_addr;
    logic [FILL_W-1:0] d_fill;
    logic              push_ok;
    logic [CARD_W-1:0] card_rd;

    assign d_head    = dst_right_reg ? right_head_reg : left_head_reg;
    assign d_fill    = dst_right_reg ? right_fill_reg : left_fill_reg;
    assign push_addr = dst_bottom_reg ? ring_add(d_head, d_fill) : ring_dec(d_head);
    assign push_ok   = move_reg && got_reg && (d_fill != FILL_W'(DEPTH));
    assign card_rd   = src_right_reg ? r_rdata : l_rdata;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic init_write, init_load, fin_load, out_load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                    state_next = is_init ? ST_INIT : ST_FIN;
            end
            ST_INIT:
            begin
                if (!init_busy && out_free)
                    state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready  = 1'b0;
        init_write = 1'b0;
        init_load  = 1'b0;
        fin_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_INIT:
            begin
                init_write = init_busy;
                init_load  = !init_busy && out_free;
            end
            ST_FIN:
            begin
                fin_load = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    assign out_load = init_load || fin_load;

    // ---------------------------------------------------------------
    // Read-modify-write datapath
    // ---------------------------------------------------------------
    logic [CARD_W-1:0] init_card;

    assign init_card = CARD_W'(left_fill_reg) + CARD_W'(1);

    always_comb
    begin
        left_head_next  = left_head_reg;
        left_fill_next  = left_fill_reg;
        right_head_next = right_head_reg;
        right_fill_next = right_fill_reg;
        init_n_next     = init_n_reg;
        move_next       = move_reg;
        got_next        = got_reg;
        src_right_next  = src_right_reg;
        dst_right_next  = dst_right_reg;
        dst_bottom_next = dst_bottom_reg;
        l_re    = 1'b0;
        r_re    = 1'b0;
        rd_addr = pop_addr;
        l_we    = 1'b0;
        r_we    = 1'b0;
        l_waddr = '0;
        r_waddr = '0;
        l_wdata = '0;
        r_wdata = '0;

        // accept: pop from the source deck, read issued now
        if (acc)
        begin
            move_next       = is_move;
            got_next        = take;
            src_right_next  = src_r;
            dst_right_next  = cmd.move_code[MC_DST_RIGHT];
            dst_bottom_next = cmd.move_code[MC_DST_BOTTOM];
            if (is_init)
            begin
                left_head_next  = '0;
                left_fill_next  = '0;
                right_head_next = '0;
                right_fill_next = '0;
                init_n_next     = init_n;
            end
            else if (take)
            begin
                if (src_r)
                begin
                    r_re            = 1'b1;
                    right_fill_next = s_fill_m1;
                    if (!src_bot)
                        right_head_next = ring_inc(right_head_reg);
                end
                else
                begin
                    l_re           = 1'b1;
                    left_fill_next = s_fill_m1;
                    if (!src_bot)
                        left_head_next = ring_inc(left_head_reg);
                end
            end
        end

        // init: card i+1 left, -(i+1) right, both at entry i
        if (init_write)
        begin
            l_we            = 1'b1;
            r_we            = 1'b1;
            l_waddr         = left_fill_reg[IDX_W-1:0];
            r_waddr         = left_fill_reg[IDX_W-1:0];
            l_wdata         = init_card;
            r_wdata         = CARD_W'(0) - init_card;
            left_fill_next  = left_fill_reg + 1'b1;
            right_fill_next = right_fill_reg + 1'b1;
        end

        // finish: push the read card onto the destination deck
        if (fin_load && push_ok)
        begin
            if (dst_right_reg)
            begin
                r_we            = 1'b1;
                r_waddr         = push_addr;
                r_wdata         = card_rd;
                right_fill_next = right_fill_reg + 1'b1;
                if (!dst_bottom_reg)
                    right_head_next = push_addr;
            end
            else
            begin
                l_we           = 1'b1;
                l_waddr        = push_addr;
                l_wdata        = card_rd;
                left_fill_next = left_fill_reg + 1'b1;
                if (!dst_bottom_reg)
                    left_head_next = push_addr;
            end
        end
    end

    always_comb
    begin
        out_card_next   = out_card_reg;
        out_cvalid_next = out_cvalid_reg;
        out_lcnt_next   = out_lcnt_reg;
        out_rcnt_next   = out_rcnt_reg;
        if (out_load)
        begin
            out_cvalid_next = fin_load && got_reg;
            out_card_next   = (fin_load && got_reg) ? card_rd : '0;
            out_lcnt_next   = CNT_W'(left_fill_next);
            out_rcnt_next   = CNT_W'(right_fill_next);
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            deck_size_reg  <= '0;
            left_head_reg  <= '0;
            left_fill_reg  <= '0;
            right_head_reg <= '0;
            right_fill_reg <= '0;
            init_n_reg     <= '0;
            move_reg       <= 1'b0;
            got_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            left_head_reg  <= left_head_next;
            left_fill_reg  <= left_fill_next;
            right_head_reg <= right_head_next;
            right_fill_reg <= right_fill_next;
            init_n_reg     <= init_n_next;
            move_reg       <= move_next;
            got_reg        <= got_next;
            if (cfg.valid && cfg.ready)
                deck_size_reg <= cfg.data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        src_right_reg  <= src_right_next;
        dst_right_reg  <= dst_right_next;
        dst_bottom_reg <= dst_bottom_next;
        out_card_reg   <= out_card_next;
        out_cvalid_reg <= out_cvalid_next;
        out_lcnt_reg   <= out_lcnt_next;
        out_rcnt_reg   <= out_rcnt_next;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.card_value  = out_card_reg;
    assign rsp.card_valid  = out_cvalid_reg;
    assign rsp.left_count  = out_lcnt_reg;
    assign rsp.right_count = out_rcnt_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (left_fill_reg + right_fill_reg) <= (FILL_W + 1)'(DEPTH))
        else $error("deck fills exceed store depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(l_we && l_re) && !(r_we && r_re))
        else $error("deck RAM read and write in the same cycle");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("pending result overwritten");

    a_init_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (left_fill_reg == right_fill_reg))
        else $error("init fills diverge");

    a_pop_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !is_init) |=> (state_reg == ST_FIN))
        else $error("item did not reach finish");

endmodule

// ----- tb/sv/dual_deque_card_mover_tb.sv -----
module dual_deque_card_mover_tb;
    import ddcm_pkg::*;

    // Run limits
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 300;    // long output stall in the backpressure test
    localparam int TAIL_CYCLES  = 8;      // settle time after the last result
    localparam int MAX_REPORTS  = 10;

    // Deck selectors as carried by move_code and read_deck
    localparam logic LEFT_DECK  = 1'b0;
    localparam logic RIGHT_DECK = 1'b1;
    localparam logic TOP_END    = 1'b0;
    localparam logic BOTTOM_END = 1'b1;

    // One response item as the checker sees it
    typedef struct packed {
        logic signed [CARD_W-1:0] value;
        logic                     valid;
        logic [CNT_W-1:0]         left_cnt;
        logic [CNT_W-1:0]         right_cnt;
    } deal_t;

    logic clk;
    logic rst_n;

    ddcm_cfg_if cfg_ch ();
    ddcm_cmd_if cmd_ch ();
    ddcm_rsp_if rsp_ch ();

    dual_deque_card_mover i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: both decks as rings, plus the deck size register.
    // ------------------------------------------------------------------
    logic signed [CARD_W-1:0] deck_mem [2][DEPTH];
    logic [IDX_W-1:0]         deck_top [2];
    logic [FILL_W-1:0]        deck_cnt [2];
    logic [SIZE_W-1:0]        size_reg;

    deal_t deal_q[$];             // expected responses, oldest first

    int  err_cnt;
    int  items_sent;
    int  cards_seen;              // responses with card_valid set
    int  cfg_writes;
    int  peak_cnt;
    int  cycle_cnt;
    bit  no_idle;                 // turns off random gaps on both sides
    bit  hold_on;                 // long output stall in progress
    event long_hold_go;

    initial begin
        deck_top[0] = '0;
        deck_top[1] = '0;
        deck_cnt[0] = '0;
        deck_cnt[1] = '0;
        size_reg    = '0;
        err_cnt     = 0;
        items_sent  = 0;
        cards_seen  = 0;
        cfg_writes  = 0;
        peak_cnt    = 0;
        cycle_cnt   = 0;
        no_idle     = 1'b0;
        hold_on     = 1'b0;
    end

    // Pop from the top or bottom of one deck; caller checks it is not empty.
    function automatic logic signed [CARD_W-1:0] take_card(input logic side,
                                                           input logic bottom);
        logic signed [CARD_W-1:0] c;
        int idx;
        if (bottom) begin
            idx = (int'(deck_top[side]) + int'(deck_cnt[side]) - 1) % DEPTH;
            c = deck_mem[side][idx];
        end else begin
            c = deck_mem[side][deck_top[side]];
            deck_top[side] = IDX_W'((int'(deck_top[side]) + 1) % DEPTH);
        end
        deck_cnt[side] = deck_cnt[side] - 1'b1;
        return c;
    endfunction

    // Push onto the top or bottom of one deck; a full deck drops the card.
    function automatic void put_card(input logic side, input logic bottom,
                                     input logic signed [CARD_W-1:0] c);
        int idx;
        if (int'(deck_cnt[side]) >= DEPTH)
            return;
        if (bottom) begin
            idx = (int'(deck_top[side]) + int'(deck_cnt[side])) % DEPTH;
            deck_mem[side][idx] = c;
        end else begin
            deck_top[side] = IDX_W'((int'(deck_top[side]) + DEPTH - 1) % DEPTH);
            deck_mem[side][deck_top[side]] = c;
        end
        deck_cnt[side] = deck_cnt[side] + 1'b1;
    endfunction

    // Apply one command item to the predictor and return its response.
    function automatic deal_t predict_deal(input logic [FUNC_W-1:0] f,
                                           input logic [CODE_W-1:0] mc,
                                           input logic rd);
        deal_t r;
        int n;
        logic signed [CARD_W-1:0] c;
        r = '0;
        case (f)
            FUNC_INIT: begin
                // oversized deck_size is clamped to MAX_CARDS
                n = (int'(size_reg) > MAX_CARDS) ? MAX_CARDS : int'(size_reg);
                deck_top[0] = '0;
                deck_top[1] = '0;
                deck_cnt[0] = '0;
                deck_cnt[1] = '0;
                for (int i = 1; i <= n; i++) begin
                    put_card(LEFT_DECK, BOTTOM_END, CARD_W'(i));
                    put_card(RIGHT_DECK, BOTTOM_END, CARD_W'(-i));
                end
            end
            FUNC_MOVE: begin
                if (deck_cnt[mc[MC_SRC_RIGHT]] != 0) begin
                    c = take_card(mc[MC_SRC_RIGHT], mc[MC_SRC_BOTTOM]);
                    put_card(mc[MC_DST_RIGHT], mc[MC_DST_BOTTOM], c);
                    r.value = c;
                    r.valid = 1'b1;
                end
            end
            FUNC_READ: begin
                if (deck_cnt[rd] != 0) begin
                    r.value = take_card(rd, TOP_END);
                    r.valid = 1'b1;
                end
            end
            default: ;    // no-op: report counts only
        endcase
        r.left_cnt  = CNT_W'(deck_cnt[0]);
        r.right_cnt = CNT_W'(deck_cnt[1]);
        return r;
    endfunction

    // Pack a move code from its four selector bits.
    function automatic logic [CODE_W-1:0] move_of(input logic src_side, input logic src_end,
                                                  input logic dst_side, input logic dst_end);
        logic [CODE_W-1:0] mc;
        mc                = '0;
        mc[MC_SRC_RIGHT]  = src_side;
        mc[MC_SRC_BOTTOM] = src_end;
        mc[MC_DST_RIGHT]  = dst_side;
        mc[MC_DST_BOTTOM] = dst_end;
        return mc;
    endfunction

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check responses, then feed accepted config and commands
    // into the predictor. Everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        deal_t got;
        deal_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.value     = rsp_ch.card_value;
                got.valid     = rsp_ch.card_valid;
                got.left_cnt  = rsp_ch.left_count;
                got.right_cnt = rsp_ch.right_count;
                if (deal_q.size() == 0) begin
                    note_error($sformatf("response with nothing pending: value=%0d valid=%0b",
                                         got.value, got.valid));
                end else begin
                    want = deal_q.pop_front();
                    if (got.value !== want.value || got.valid !== want.valid ||
                        got.left_cnt !== want.left_cnt || got.right_cnt !== want.right_cnt)
                        note_error($sformatf(
                            "exp value=%0d valid=%0b left=%0d right=%0d, got value=%0d %s",
                            want.value, want.valid, want.left_cnt, want.right_cnt,
                            got.value, $sformatf("valid=%0b left=%0d right=%0d",
                                                 got.valid, got.left_cnt, got.right_cnt)));
                    if (want.valid)
                        cards_seen++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                size_reg = cfg_ch.data;
            if (cmd_ch.valid && cmd_ch.ready) begin
                want = predict_deal(cmd_ch.func, cmd_ch.move_code, cmd_ch.read_deck);
                deal_q.push_back(want);
                if (int'(want.left_cnt) > peak_cnt)
                    peak_cnt = int'(want.left_cnt);
                if (int'(want.right_cnt) > peak_cnt)
                    peak_cnt = int'(want.right_cnt);
            end
        end
    end

    // ------------------------------------------------------------------
    // Response ready: random stall bursts, the long hold, or always ready.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        int stall_left;
        if (hold_on) begin
            rsp_ch.ready <= 1'b0;
        end else if (no_idle) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Long hold on the response side, counted here so the sender keeps going.
    initial begin
        forever begin
            @(long_hold_go);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d responses pending", cycle_cnt,
                     deal_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one command item and wait until it is taken. valid is left high
    // between back-to-back items.
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] mc,
                            input logic rd);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= f;
        cmd_ch.move_code <= mc;
        cmd_ch.read_deck <= rd;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every response is back.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (deal_q.size() != 0)
            @(posedge clk);
    endtask

    // Write deck_size with the block idle.
    task automatic new_deck_size(input logic [SIZE_W-1:0] n);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_random_move();
        send_cmd(FUNC_MOVE, CODE_W'($urandom), 1'($urandom));
    endtask

    // Random mix: mostly moves, with some readouts, re-inits and no-ops.
    task automatic play_random(input int n_items);
        int pick;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_cmd(FUNC_INIT, CODE_W'($urandom), 1'($urandom));
            else if (pick < 10)
                send_cmd(FUNC_READ, CODE_W'($urandom), 1'($urandom));
            else if (pick < 13)
                send_cmd(FUNC_NOP, CODE_W'($urandom), 1'($urandom));
            else
                send_random_move();
        end
    endtask

    // Mostly small decks so inits stay short; now and then any 9-bit value.
    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(0, 9) == 0)
            return SIZE_W'($urandom);
        return SIZE_W'($urandom_range(1, 24));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: decks empty, deck_size still zero.
    task automatic test_empty_decks();
        send_cmd(FUNC_NOP, '1, 1'b1);
        send_cmd(FUNC_MOVE, move_of(RIGHT_DECK, BOTTOM_END, LEFT_DECK, TOP_END), 1'b0);
        send_cmd(FUNC_READ, '0, RIGHT_DECK);
        send_cmd(FUNC_INIT, '0, 1'b0);
    endtask

    // Every move code once on small decks.
    task automatic test_all_move_codes();
        new_deck_size(SIZE_W'(3));
        send_cmd(FUNC_INIT, '0, 1'b0);
        for (int mc = 0; mc < 16; mc++)
            send_cmd(FUNC_MOVE, CODE_W'(mc), 1'b0);
    endtask

    // deck_size at zero, one, the maximum, just above it and all ones.
    task automatic test_size_extremes();
        new_deck_size('0);
        new_deck_size(SIZE_W'(1));
        send_cmd(FUNC_INIT, '0, 1'b0);
        new_deck_size(SIZE_W'(MAX_CARDS));
        send_cmd(FUNC_INIT, '0, 1'b0);
        new_deck_size(SIZE_W'(MAX_CARDS + 1));
        send_cmd(FUNC_INIT, '0, 1'b0);
        new_deck_size('1);
        send_cmd(FUNC_INIT, '1, 1'b1);
        send_cmd(FUNC_READ, '0, LEFT_DECK);
        send_cmd(FUNC_READ, '0, RIGHT_DECK);
    endtask

    // Move the whole right deck onto the left one so the left count
    // reaches the full store depth, then poke the now empty right deck.
    task automatic test_fill_one_deck();
        new_deck_size(SIZE_W'(MAX_CARDS));
        send_cmd(FUNC_INIT, '0, 1'b0);
        repeat (MAX_CARDS)
            send_cmd(FUNC_MOVE, move_of(RIGHT_DECK, 1'($urandom), LEFT_DECK,
                                        1'($urandom)), 1'b0);
        send_cmd(FUNC_READ, '0, RIGHT_DECK);
        send_cmd(FUNC_MOVE, move_of(RIGHT_DECK, TOP_END, LEFT_DECK, BOTTOM_END), 1'b0);
        repeat (4)
            send_random_move();
    endtask

    // Several phases with a fresh deck size each.
    task automatic test_random_play();
        for (int ph = 0; ph < 5; ph++) begin
            new_deck_size(pick_size());
            send_cmd(FUNC_INIT, '0, 1'b0);
            play_random(250);
        end
    endtask

    // Hold the response side for a long time while commands keep coming.
    task automatic test_output_backpressure();
        new_deck_size(SIZE_W'(12));
        send_cmd(FUNC_INIT, '0, 1'b0);
        -> long_hold_go;
        repeat (40)
            send_random_move();
    endtask

    // Last stretch with no gaps on either side.
    task automatic test_full_rate();
        wait_drained();
        no_idle = 1'b1;
        new_deck_size(SIZE_W'(20));
        send_cmd(FUNC_INIT, '0, 1'b0);
        play_random(200);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.func      = '0;
        cmd_ch.move_code = '0;
        cmd_ch.read_deck = 1'b0;
        rsp_ch.ready     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_decks();
        test_all_move_codes();
        test_size_extremes();
        test_fill_one_deck();
        test_random_play();
        test_output_backpressure();
        test_full_rate();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (deal_q.size() != 0)
            note_error($sformatf("%0d responses never arrived", deal_q.size()));

        $display("Ran %0d command items, %0d deck size writes, %0d cards moved or popped,",
                 items_sent, cfg_writes, cards_seen);
        $display("deepest deck %0d cards, %0d errors", peak_cnt, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
